>>> hdl/rpnp_pkg.sv
// Shared types and constants for the radix prefixed number parser.
// No dependencies; every file but rpnp_fifo refers to this package by scoped names.
package rpnp_pkg;

    localparam int unsigned BASE_W        = 6;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned KIND_W        = 2;
    localparam int unsigned OP_W          = 3;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_HEX_PREFIX_LIMIT = 6'd33;

    // Operations passed from the classifier to the executor.
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DIGIT = 3'd1;
    localparam logic [OP_W-1:0] OP_DASH  = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd3;
    localparam logic [OP_W-1:0] OP_BAD   = 3'd4;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd5;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SINGLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

    // One classified character. The value field carries a digit for OP_DIGIT and the raw
    // character for OP_LOAD. pre_zero asks the executor to apply a leading zero digit first.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              pre_zero;
        logic [CHAR_W-1:0] val;
        logic [BASE_W-1:0] base;
        logic              last;
    } t_op;

    localparam int unsigned OP_BITS = $bits(t_op);

endpackage

>>> hdl/radix_prefixed_number_parser_top.sv
// Top level of the radix prefixed number parser: base register, classifier, queue, executor.
// Depends on rpnp_pkg, rpnp_front, rpnp_fifo and rpnp_back.
//
//  channel   direction  tdata fields (low bit up)          tuser  tlast
//  s_axis    in         ch[7:0]                            -      last
//  m_axis    out        kind[1:0], value[65:2], pad[71:66] -      -
//  cfg       in         number_base[5:0] on i_cfg_wen      -      -
//
// One character request is taken every cycle; the classifier never waits on the executor
// unless the four-entry queue is full.
// Results reach m_axis through the queue and the executor's output register.
// Reset clears the token state and sets the base to ten.
// A stalled result holds in the executor's output register while the queue keeps filling.
module radix_prefixed_number_parser_top #(
    parameter int unsigned QUEUE_DEPTH = rpnp_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [rpnp_pkg::BASE_W-1:0]   i_cfg_wdata,      // number_base
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,     // ch[7:0]
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [71:0]                   m_axis_tdata      // kind[1:0], value[65:2], zeros
);

    logic [rpnp_pkg::BASE_W-1:0]  r_number_base;
    logic                         w_accept;
    logic                         w_full;
    rpnp_pkg::t_op                w_front_op;
    logic                         w_q_valid;
    logic [rpnp_pkg::OP_BITS-1:0] w_q_data;
    rpnp_pkg::t_op                w_back_op;
    logic                         w_pop;
    logic [rpnp_pkg::KIND_W-1:0]  w_kind;
    logic [rpnp_pkg::VALUE_W-1:0] w_value;

    // The user must change the default base only while no token is in flight; the block does not
    // enforce this. The classifier latches the base at a token's first character unless that is a prefix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= rpnp_pkg::BASE_RESET;
        end else if (i_cfg_wen) begin
            r_number_base <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && !w_full;

    rpnp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_number_base (r_number_base),
        .i_accept      (w_accept),
        .i_ch          (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_op          (w_front_op)
    );

    rpnp_fifo #(
        .WIDTH (rpnp_pkg::OP_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_back_op = rpnp_pkg::t_op'(w_q_data);

    rpnp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_q_valid),
        .i_op        (w_back_op),
        .o_op_pop    (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_kind  (w_kind),
        .o_res_value (w_value)
    );

    assign m_axis_tdata = {6'd0, w_value, w_kind};

endmodule

>>> hdl/rpnp_front.sv
// Classifier of the radix prefixed number parser: tracks prefixes and turns each character
// into an operation for the executor. Depends on rpnp_pkg.
module rpnp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [rpnp_pkg::BASE_W-1:0]      i_number_base,
    input  logic                             i_accept,
    input  logic [rpnp_pkg::CHAR_W-1:0]      i_ch,
    input  logic                             i_last,
    output rpnp_pkg::t_op                    o_op
);

    localparam logic [2:0] PH_FIRST      = 3'd0;
    localparam logic [2:0] PH_BODY       = 3'd1;
    localparam logic [2:0] PH_ZERO       = 3'd2;
    localparam logic [2:0] PH_QUOTE      = 3'd3;
    localparam logic [2:0] PH_QUOTE_DONE = 3'd4;

    logic [2:0]                    r_phase;
    logic [2:0]                    n_phase;
    logic [rpnp_pkg::BASE_W-1:0]   r_base;
    logic [rpnp_pkg::BASE_W-1:0]   n_base;
    rpnp_pkg::t_op                 w_op;

    // Plain character class in a body position.
    function automatic logic [rpnp_pkg::OP_W+rpnp_pkg::CHAR_W-1:0] classify(
        input logic [rpnp_pkg::CHAR_W-1:0] c
    );
        logic [rpnp_pkg::OP_W-1:0]   op;
        logic [rpnp_pkg::CHAR_W-1:0] v;
        op = rpnp_pkg::OP_BAD;
        v  = '0;
        if (c inside {["0":"9"]}) begin
            op = rpnp_pkg::OP_DIGIT;
            v  = c - 8'h30;
        end else if (c inside {["a":"z"]}) begin
            op = rpnp_pkg::OP_DIGIT;
            v  = c - 8'h61 + 8'd10;
        end else if (c inside {["A":"Z"]}) begin
            op = rpnp_pkg::OP_DIGIT;
            v  = c - 8'h41 + 8'd10;
        end else if (c == "-") begin
            op = rpnp_pkg::OP_DASH;
        end else if (c inside {",", ".", "+", "/", ":"}) begin
            op = rpnp_pkg::OP_MARK;
        end
        return {op, v};
    endfunction

    always_comb begin
        n_phase       = r_phase;
        n_base        = r_base;
        w_op.op       = rpnp_pkg::OP_NONE;
        w_op.pre_zero = 1'b0;
        w_op.val      = '0;
        w_op.base     = r_base;
        w_op.last     = i_last;
        case (r_phase)
            PH_FIRST: begin
                n_phase = PH_BODY;
                case (i_ch)
                    "&", "#": n_base = rpnp_pkg::BASE_DEC;
                    "%":      n_base = rpnp_pkg::BASE_BIN;
                    "$":      n_base = rpnp_pkg::BASE_HEX;
                    "0": begin
                        n_base  = i_number_base;
                        n_phase = PH_ZERO;
                    end
                    "'":      n_phase = PH_QUOTE;
                    default: begin
                        n_base             = i_number_base;
                        {w_op.op, w_op.val} = classify(i_ch);
                    end
                endcase
                w_op.base = n_base;
            end
            PH_ZERO: begin
                n_phase = PH_BODY;
                if (i_ch == "x" && r_base < rpnp_pkg::BASE_HEX_PREFIX_LIMIT) begin
                    n_base = rpnp_pkg::BASE_HEX;
                end else begin
                    {w_op.op, w_op.val} = classify(i_ch);
                    w_op.pre_zero       = 1'b1;
                end
            end
            PH_QUOTE: begin
                n_phase  = PH_QUOTE_DONE;
                w_op.op  = rpnp_pkg::OP_LOAD;
                w_op.val = i_ch;
            end
            PH_QUOTE_DONE: ;
            PH_BODY: {w_op.op, w_op.val} = classify(i_ch);
            default: n_phase = PH_FIRST;
        endcase
        // A lone leading zero still counts as a digit at the end of the token.
        if (i_last && n_phase == PH_ZERO) begin
            w_op.pre_zero = 1'b1;
        end
        if (i_last) begin
            n_phase = PH_FIRST;
            n_base  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_base  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_base  <= n_base;
        end
    end

    assign o_op = w_op;

endmodule

>>> hdl/rpnp_fifo.sv
// Short register queue that decouples the classifier from the executor.
// Depends on nothing but its parameters; widths are set by the instantiating module.
module rpnp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

>>> hdl/rpnp_back.sv
// Executor of the radix prefixed number parser: accumulates digits, keeps the sign, double
// and invalid flags, and holds the result in an output register. Depends on rpnp_pkg.
module rpnp_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_op_valid,
    input  rpnp_pkg::t_op                    i_op,
    output logic                             o_op_pop,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [rpnp_pkg::KIND_W-1:0]      o_res_kind,
    output logic [rpnp_pkg::VALUE_W-1:0]     o_res_value
);

    logic [rpnp_pkg::VALUE_W-1:0] r_acc;
    logic [rpnp_pkg::VALUE_W-1:0] n_acc;
    logic                         r_dz;
    logic                         n_dz;
    logic                         r_neg;
    logic                         n_neg;
    logic                         r_dbl;
    logic                         n_dbl;
    logic                         r_inv;
    logic                         n_inv;

    logic                         r_ovalid;
    logic [rpnp_pkg::KIND_W-1:0]  r_okind;
    logic [rpnp_pkg::VALUE_W-1:0] r_oval;

    logic                         w_pop;
    logic [rpnp_pkg::VALUE_W-1:0] w_prod;
    logic [rpnp_pkg::VALUE_W-1:0] w_dig;
    logic [rpnp_pkg::VALUE_W-1:0] w_mac;

    // A result-bearing operation needs room in the output register.
    assign w_pop = i_op_valid && (!i_op.last || !r_ovalid || i_res_ready);

    // The minus sign always arrives before any digit, so a negative number is built by
    // subtracting digits and needs no final negation.
    assign w_prod = r_acc * {{(rpnp_pkg::VALUE_W-rpnp_pkg::BASE_W){1'b0}}, i_op.base};
    assign w_dig  = {{(rpnp_pkg::VALUE_W-rpnp_pkg::BASE_W){1'b0}}, i_op.val[rpnp_pkg::BASE_W-1:0]};
    assign w_mac  = r_neg ? (w_prod - w_dig) : (w_prod + w_dig);

    always_comb begin
        n_acc = r_acc;
        n_dz  = r_dz;
        n_neg = r_neg;
        n_dbl = r_dbl;
        n_inv = r_inv;
        if (i_op.pre_zero) begin
            n_dz = 1'b0;
            if (i_op.base == '0) begin
                n_inv = 1'b1;
            end
        end
        if (!n_inv) begin
            case (i_op.op)
                rpnp_pkg::OP_DIGIT: begin
                    n_dz = 1'b0;
                    if (i_op.val[rpnp_pkg::BASE_W-1:0] >= i_op.base) begin
                        n_inv = 1'b1;
                    end else begin
                        n_acc = w_mac;
                    end
                end
                rpnp_pkg::OP_DASH: begin
                    if (n_dz) begin
                        n_neg = 1'b1;
                    end else begin
                        n_dbl = 1'b1;
                    end
                    n_dz = 1'b0;
                end
                rpnp_pkg::OP_MARK: begin
                    n_dbl = 1'b1;
                    n_dz  = 1'b0;
                end
                rpnp_pkg::OP_BAD:  n_inv = 1'b1;
                rpnp_pkg::OP_LOAD: n_acc = {{(rpnp_pkg::VALUE_W-rpnp_pkg::CHAR_W){1'b0}}, i_op.val};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_dz  <= 1'b1;
            r_neg <= 1'b0;
            r_dbl <= 1'b0;
            r_inv <= 1'b0;
        end else if (w_pop) begin
            if (i_op.last) begin
                r_acc <= '0;
                r_dz  <= 1'b1;
                r_neg <= 1'b0;
                r_dbl <= 1'b0;
                r_inv <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_dz  <= n_dz;
                r_neg <= n_neg;
                r_dbl <= n_dbl;
                r_inv <= n_inv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_pop && i_op.last) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_op.last) begin
            r_okind <= n_inv ? rpnp_pkg::KIND_INVALID :
                       (n_dbl ? rpnp_pkg::KIND_DOUBLE : rpnp_pkg::KIND_SINGLE);
            r_oval  <= n_inv ? '0 : n_acc;
        end
    end

    assign o_op_pop    = w_pop;
    assign o_res_valid = r_ovalid;
    assign o_res_kind  = r_okind;
    assign o_res_value = r_oval;

`ifndef SYNTHESIS
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_okind == rpnp_pkg::KIND_SINGLE || r_okind == rpnp_pkg::KIND_DOUBLE ||
                      r_okind == rpnp_pkg::KIND_INVALID))
        else $error("result kind out of range");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_okind == rpnp_pkg::KIND_INVALID) |-> (r_oval == '0))
        else $error("invalid token with non-zero value");
    a_token_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_op.last) |=> (r_acc == '0 && r_dz && !r_neg && !r_dbl && !r_inv))
        else $error("token state not cleared after last character");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_res_ready) |-> !(w_pop && i_op.last))
        else $error("pending result overwritten");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for radix_prefixed_number_parser_top: characters in, numbers out.
// Depends on rpnp_pkg and the parser top level only; it carries its own model of the conversion.
module testbench;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_CHARS   = 140;
    localparam string MARK_SET   = ",.+-/:";

    // Where the converter stands within the current token.
    localparam logic [2:0] SCAN_FIRST      = 3'd0;
    localparam logic [2:0] SCAN_BODY       = 3'd1;
    localparam logic [2:0] SCAN_ZERO       = 3'd2;
    localparam logic [2:0] SCAN_QUOTE      = 3'd3;
    localparam logic [2:0] SCAN_QUOTE_DONE = 3'd4;

    // One character request as it goes onto s_axis.
    typedef struct packed {
        logic [rpnp_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_char_req;

    // One parsed number as it comes off m_axis.
    typedef struct packed {
        logic [rpnp_pkg::KIND_W-1:0]  kind;
        logic [rpnp_pkg::VALUE_W-1:0] value;
    } t_parse_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wen = 1'b0;
    logic [rpnp_pkg::BASE_W-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    t_char_req char_requests[$];
    t_parse_result expected_numbers[$];

    // Model of the converter: configured base and the state of the token in flight.
    logic [rpnp_pkg::BASE_W-1:0]  cfg_base;
    logic [2:0]                   scan_state;
    logic [rpnp_pkg::BASE_W-1:0]  scan_base;
    logic [rpnp_pkg::VALUE_W-1:0] scan_acc;
    logic                         scan_fresh;
    logic                         scan_neg;
    logic                         scan_dbl;
    logic                         scan_bad;

    int fail_cnt = 0;
    int cycle_cnt = 0;
    int chars_queued = 0;
    int tx_wait = 0;
    int tx_idle_max = 14;
    int rx_wait = 0;
    int rx_idle_max = 14;
    int rx_hold = 0;

    radix_prefixed_number_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),      // number_base
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // ch[7:0]
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)      // kind[1:0], value[65:2], zeros
    );

    always #5 i_clk = ~i_clk;

    // Every token leaves the converter in the same clean state, whatever it held.
    function automatic void clear_token();
        scan_state = SCAN_FIRST;
        scan_base  = '0;
        scan_acc   = '0;
        scan_fresh = 1'b1;
        scan_neg   = 1'b0;
        scan_dbl   = 1'b0;
        scan_bad   = 1'b0;
    endfunction

    // A character after any prefix: a digit, a sign, a double-number mark or rubbish.
    function automatic void feed_body(input logic [rpnp_pkg::CHAR_W-1:0] c);
        logic [rpnp_pkg::VALUE_W-1:0] digit;
        digit = '0;
        if (scan_bad) return;
        if (c >= "0" && c <= "9") begin
            digit = 64'(c - "0");
        end else if (c >= "a" && c <= "z") begin
            digit = 64'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "Z") begin
            digit = 64'(c - "A" + 8'd10);
        end else if (scan_fresh && c == "-") begin
            // Only a minus ahead of every digit and mark negates.
            scan_neg   = 1'b1;
            scan_fresh = 1'b0;
            return;
        end else if (c == "," || c == "." || c == "+" || c == "-" || c == "/" || c == ":") begin
            scan_dbl   = 1'b1;
            scan_fresh = 1'b0;
            return;
        end else begin
            scan_bad = 1'b1;
            return;
        end
        scan_fresh = 1'b0;
        if (digit >= 64'(scan_base)) begin
            scan_bad = 1'b1;
            return;
        end
        scan_acc = scan_acc * 64'(scan_base) + digit;
    endfunction

    // Advances the model by one accepted character; returns 1 when a number is due.
    function automatic bit convert_char(input logic [rpnp_pkg::CHAR_W-1:0] c, input logic lst,
                                        output t_parse_result r);
        r = '0;
        case (scan_state)
            SCAN_FIRST: begin
                scan_state = SCAN_BODY;
                if (c == "&" || c == "#") begin
                    scan_base = rpnp_pkg::BASE_DEC;
                end else if (c == "%") begin
                    scan_base = rpnp_pkg::BASE_BIN;
                end else if (c == "$") begin
                    scan_base = rpnp_pkg::BASE_HEX;
                end else if (c == "0") begin
                    // Could still turn into the hex prefix.
                    scan_base  = cfg_base;
                    scan_state = SCAN_ZERO;
                end else if (c == "'") begin
                    scan_state = SCAN_QUOTE;
                end else begin
                    scan_base = cfg_base;
                    feed_body(c);
                end
            end
            SCAN_ZERO: begin
                scan_state = SCAN_BODY;
                if (c == "x" && scan_base < rpnp_pkg::BASE_HEX_PREFIX_LIMIT) begin
                    scan_base = rpnp_pkg::BASE_HEX;
                end else begin
                    feed_body("0");
                    feed_body(c);
                end
            end
            SCAN_QUOTE: begin
                scan_acc   = 64'(c);
                scan_state = SCAN_QUOTE_DONE;
            end
            SCAN_QUOTE_DONE: begin
                // Anything after the quoted character is ignored.
            end
            default: begin
                feed_body(c);
            end
        endcase
        if (!lst) return 1'b0;
        // A lone leading zero is simply the digit zero.
        if (scan_state == SCAN_ZERO) feed_body("0");
        if (scan_bad) begin
            r.kind  = rpnp_pkg::KIND_INVALID;
            r.value = '0;
        end else begin
            r.kind  = scan_dbl ? rpnp_pkg::KIND_DOUBLE : rpnp_pkg::KIND_SINGLE;
            r.value = scan_neg ? 64'd0 - scan_acc : scan_acc;
        end
        clear_token();
        return 1'b1;
    endfunction

    function automatic void push_char(input logic [rpnp_pkg::CHAR_W-1:0] c, input logic lst);
        char_requests.push_back('{ch: c, last: lst});
        chars_queued++;
    endfunction

    function automatic void push_token(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [rpnp_pkg::CHAR_W-1:0] digit_char(input int d);
        if (d < 10) return 8'("0" + d);
        if ($urandom_range(0, 1) == 1) return 8'("a" + d - 10);
        return 8'("A" + d - 10);
    endfunction

    // Mostly well-formed numbers with random prefixes, signs, marks and lengths; the rest are
    // quoted characters and plain noise over the whole character range.
    function automatic void push_random_token();
        logic [rpnp_pkg::CHAR_W-1:0] tok[$];
        int sel;
        int n;
        int eff;
        int d;
        sel = $urandom_range(0, 99);
        eff = int'(cfg_base);
        if (sel < 70) begin
            case ($urandom_range(0, 7))
                0: begin tok.push_back("&"); eff = 10; end
                1: begin tok.push_back("#"); eff = 10; end
                2: begin tok.push_back("%"); eff = 2; end
                3: begin tok.push_back("$"); eff = 16; end
                4: begin
                    tok.push_back("0");
                    tok.push_back("x");
                    if (eff < 33) eff = 16;
                end
                default: begin end
            endcase
            if ($urandom_range(0, 3) == 0) tok.push_back("-");
            // Long runs of digits can make the accumulator wrap.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    tok.push_back(MARK_SET[$urandom_range(0, 5)]);
                end else begin
                    if (eff < 2 || $urandom_range(0, 19) == 0)
                        d = (eff == 1) ? 0 : $urandom_range(0, 35);
                    else
                        d = $urandom_range(0, (eff > 36) ? 35 : eff - 1);
                    tok.push_back(digit_char(d));
                end
            end
            if ($urandom_range(0, 19) == 0) tok.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 82) begin
            tok.push_back("'");
            if ($urandom_range(0, 7) != 0) tok.push_back(8'($urandom_range(0, 255)));
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++) tok.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) tok.push_back(8'($urandom_range(0, 255)));
        end
        if (tok.size() == 0) tok.push_back("0");
        for (int i = 0; i < tok.size(); i++) push_char(tok[i], i == tok.size() - 1);
    endfunction

    // The base register is only written once the parser has drained.
    task automatic write_base(input logic [rpnp_pkg::BASE_W-1:0] b);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        cfg_base = b;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (char_requests.size() != 0 || s_axis_tvalid || expected_numbers.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Character driver: holds a request until it is taken, then idles for the drawn gap.
    always @(posedge i_clk) begin : drive_chars
        t_parse_result res;
        t_char_req item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (convert_char(s_axis_tdata, s_axis_tlast, res)) expected_numbers.push_back(res);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (char_requests.size() != 0) begin
                    item = char_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.ch;
                    s_axis_tlast  <= item.last;
                    tx_wait = $urandom_range(0, tx_idle_max);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted number against the oldest prediction and stalls
    // the parser after it for the drawn number of cycles, or for a long hold-off when asked.
    always @(posedge i_clk) begin : check_numbers
        t_parse_result seen;
        t_parse_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind  = m_axis_tdata[1:0];
                seen.value = m_axis_tdata[65:2];
                if (expected_numbers.size() == 0) begin
                    $error("unexpected result: kind %0d, value %h", seen.kind, seen.value);
                    fail_cnt++;
                end else begin
                    want = expected_numbers.pop_front();
                    if (seen.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, seen.kind);
                        fail_cnt++;
                    end
                    if (seen.value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, seen.value);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[71:66] !== '0) begin
                        $error("pad: expected 0, got %h", m_axis_tdata[71:66]);
                        fail_cnt++;
                    end
                end
                rx_wait = $urandom_range(0, rx_idle_max);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_hold > 0) rx_hold--;
            m_axis_tready <= (rx_wait == 0 && rx_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        logic [rpnp_pkg::BASE_W-1:0] base_plan [10];
        int start;
        cfg_base = rpnp_pkg::BASE_RESET;
        clear_token();
        // Extremes of the register, both sides of the hex-prefix limit and one random base.
        base_plan = '{6'd36, 6'd2, 6'd0, 6'd63, 6'd16, 6'd1, 6'd37, 6'd8, 6'd10, 6'd32};
        base_plan[8] = 6'($urandom_range(3, 35));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed tokens at the reset base of ten.
        @(negedge i_clk);
        push_token("&");          // prefix on its own
        push_token("#-9");        // decimal prefix then a negation
        push_token("%1");
        push_token("$fF");        // hex digits in both cases
        push_token("0x");         // hex prefix on its own
        push_token("'");          // apostrophe as the final character
        push_char("'", 1'b0);
        push_char(8'hff, 1'b1);   // quoted top character code
        push_token("0");          // lone leading zero
        push_token("-");
        push_token("1,");         // double number
        push_token("z");          // digit not below the base
        push_char(8'h00, 1'b1);   // character code zero is rubbish
        push_token("9/:");
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            write_base(base_plan[p]);
            @(negedge i_clk);
            tx_idle_max = (p % 3 == 1) ? 0 : 14;
            rx_idle_max = (p % 4 == 2) ? 0 : 14;
            if (p == 4) begin
                // The sink holds off while the source floods, so the internal queue fills and
                // the parser has to refuse character requests.
                tx_idle_max = 0;
                rx_hold = 400;
            end
            start = chars_queued;
            while (chars_queued - start < PHASE_CHARS) push_random_token();
            wait_idle();
        end

        if (fail_cnt == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> radix_prefixed_number_parser_top.f
hdl/rpnp_pkg.sv
hdl/rpnp_front.sv
hdl/rpnp_fifo.sv
hdl/rpnp_back.sv
hdl/radix_prefixed_number_parser_top.sv
test/testbench.sv
